// ===== hdl/weo_pkg.sv =====
package weo_pkg;

  // Shared divider geometry: magnitude numerator, scaled divisor, quotient bits
  localparam int unsigned DIV_NUM_W = 46;
  localparam int unsigned DIV_DEN_W = 30;
  localparam int unsigned DIV_Q_W   = 17;
  localparam int unsigned DIV_CNT_W = 5;

  // Scale factors
  localparam logic [30:0] SPEED_NUM = 31'd1225221134;
  localparam logic [13:0] SPEED_DEN = 14'd9097;
  localparam logic [10:0] DIST_NUM  = 11'd1225;
  localparam logic [13:0] DIST_DEN  = 14'd9097;

  // Register reset values
  localparam logic [15:0] AVG_INTERVAL_RST = 16'd2000;
  localparam logic [15:0] STANDSTILL_RST   = 16'd5000;

  // Configuration register indexes
  localparam logic CFG_AVG_INTERVAL = 1'b0;
  localparam logic CFG_STANDSTILL   = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== hdl/weo_divider.sv =====
module weo_divider import weo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] rem_r;
  logic [DIV_NUM_W-1:0] ds_r;
  logic [DIV_Q_W-1:0]   quo_r;
  logic                 ovf_r;
  logic                 ge;

  assign ge = (rem_r >= ds_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle from the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      ds_r  <= {req.den, (DIV_Q_W-1)'(0)};
      quo_r <= '0;
      ovf_r <= ({1'b0, req.num} >= {req.den, DIV_Q_W'(0)});
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - ds_r;
      end
      quo_r <= {quo_r[DIV_Q_W-2:0], ge};
      ds_r  <= ds_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== hdl/wheel_encoder_odometry_core.sv =====
// Wheel encoder odometry. Each input beat carries both wheel counts and two
// timestamps; each produces exactly one output beat with the speed of that
// sample, the peak speed, the accumulated distance, the windowed average
// velocity and a moving flag. For a beat whose counts differ from the last
// ones, one shared shift-subtract divider resolves 17 quotient bits, one per
// cycle, for the left speed, the right speed and the distance step in turn,
// each division preceded by its load step. A beat with unchanged counts skips
// the divider. The next beat can be taken in the cycle after the result is
// loaded; the block takes no new beat before it is through with the last one.
// in_tready is high only while the block is idle with no result to load; a
// finished result waits in the output register while the next beat is taken,
// and a held result stalls only the loading of the following one.
// Configuration is written through cfg_we, cfg_addr (0: average interval in
// ms, 1: standstill timeout in us) and cfg_wdata.
module wheel_encoder_odometry_core import weo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // left_count[15:0], right_count[31:16], time_us[47:32], time_ms[79:48]
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // speed[15:0], max_speed[31:16], distance[63:32], average_velocity[79:64],
  // moving[80], zero[87:81]
  output logic [87:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DELTA = 10'b0000000010,
    ST_DEN   = 10'b0000000100,
    ST_LD_L  = 10'b0000001000,
    ST_DV_L  = 10'b0000010000,
    ST_LD_R  = 10'b0000100000,
    ST_DV_R  = 10'b0001000000,
    ST_LD_D  = 10'b0010000000,
    ST_DV_D  = 10'b0100000000,
    ST_FIN   = 10'b1000000000
  } state_t;

  // Result is written from ST_FIN's follow-up; window state uses its own step
  logic win_pend_r;

  state_t state_r;

  logic [15:0] avg_interval_r;
  logic [15:0] standstill_r;

  // Captured beat
  logic [15:0] in_left_r;
  logic [15:0] in_right_r;
  logic [15:0] in_us_r;
  logic [31:0] in_ms_r;

  // Block state
  logic [15:0] last_left_r;
  logic [15:0] last_right_r;
  logic [15:0] last_change_r;
  logic [31:0] distance_r;
  logic [15:0] peak_r;
  logic [31:0] win_start_r;
  logic [31:0] win_dist_r;
  logic [15:0] avg_vel_r;

  // Working registers
  logic        changed;
  logic        changed_r;
  logic [15:0] dl_r;
  logic [15:0] dr_r;
  logic [15:0] gap_r;
  logic [29:0] den_r;
  logic [15:0] half_r;
  logic [15:0] sl_r;
  logic [15:0] sr_r;
  logic [31:0] step_r;
  logic [15:0] speed_r;

  logic                 req_start_r;
  logic [DIV_NUM_W-1:0] req_num_r;
  logic [DIV_DEN_W-1:0] req_den_r;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic        out_valid_r;
  logic [87:0] out_data_r;
  logic        out_free;

  // Window step values
  logic [15:0] idle_us;
  logic [31:0] ms_gap;
  logic [32:0] gain;
  logic [32:0] gain_adj;
  logic [31:0] gain_half;
  logic [15:0] gain_sat;
  logic [15:0] speed_avg;
  logic [15:0] dist_half;

  function automatic logic [15:0] half_sum(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] s_adj;
    s     = {a[15], a} + {b[15], b};
    s_adj = s + {16'b0, s[16]};
    return s_adj[16:1];
  endfunction

  function automatic logic [15:0] mag16(input logic [15:0] v);
    return v[15] ? (16'd0 - v) : v;
  endfunction

  // Apply the sign and clamp to 16 bits signed
  function automatic logic [15:0] sat_speed(input logic neg, input div_rsp_t r);
    logic [15:0] res;
    if (neg) begin
      if (r.ovf || r.quo > DIV_Q_W'(32768)) res = 16'h8000;
      else                                  res = 16'd0 - r.quo[15:0];
    end else begin
      if (r.ovf || r.quo > DIV_Q_W'(32767)) res = 16'h7FFF;
      else                                  res = r.quo[15:0];
    end
    return res;
  endfunction

  assign div_req.start = req_start_r;
  assign div_req.num   = req_num_r;
  assign div_req.den   = req_den_r;

  weo_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready  = (state_r == ST_IDLE) && !win_pend_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign changed   = (in_left_r != last_left_r) || (in_right_r != last_right_r);
  assign speed_avg = half_sum(sl_r, sr_r);
  assign dist_half = half_sum(dl_r, dr_r);

  assign idle_us   = in_us_r - last_change_r;
  assign ms_gap    = in_ms_r - win_start_r;
  assign gain      = {distance_r[31], distance_r} - {win_dist_r[31], win_dist_r};
  assign gain_adj  = gain + {32'b0, gain[32]};
  assign gain_half = gain_adj[32:1];

  always_comb begin
    if (!gain_half[31] && (gain_half[30:15] != 16'h0000)) begin
      gain_sat = 16'h7FFF;
    end else if (gain_half[31] && (gain_half[30:15] != 16'hFFFF)) begin
      gain_sat = 16'h8000;
    end else begin
      gain_sat = gain_half[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_interval_r <= AVG_INTERVAL_RST;
      standstill_r   <= STANDSTILL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_AVG_INTERVAL: avg_interval_r <= cfg_wdata;
        CFG_STANDSTILL:   standstill_r   <= cfg_wdata;
        default:          avg_interval_r <= avg_interval_r;
      endcase
    end
  end

  // Sequencer and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      win_pend_r    <= 1'b0;
      req_start_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      last_left_r   <= '0;
      last_right_r  <= '0;
      last_change_r <= '0;
      distance_r    <= '0;
      peak_r        <= '0;
      win_start_r   <= '0;
      win_dist_r    <= '0;
      avg_vel_r     <= '0;
    end else begin
      req_start_r <= 1'b0;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (win_pend_r) begin
            if (out_free) begin
              win_pend_r  <= 1'b0;
              out_valid_r <= 1'b1;
              if (idle_us > standstill_r) begin
                win_start_r <= '0;
                avg_vel_r   <= '0;
                peak_r      <= '0;
                win_dist_r  <= distance_r;
                out_data_r  <= {7'b0, 1'b0, 16'h0000, distance_r, 16'h0000, speed_r};
              end else if (ms_gap > {16'b0, avg_interval_r}) begin
                win_start_r <= in_ms_r;
                avg_vel_r   <= gain_sat;
                win_dist_r  <= distance_r;
                out_data_r  <= {7'b0, 1'b1, gain_sat, distance_r, peak_r, speed_r};
              end else begin
                out_data_r  <= {7'b0, 1'b1, avg_vel_r, distance_r, peak_r, speed_r};
              end
            end
          end else if (in_tvalid) begin
            state_r <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          if (changed) state_r <= ST_DEN;
          else         state_r <= ST_FIN;
        end
        ST_DEN: begin
          state_r <= ST_LD_L;
        end
        ST_LD_L: begin
          req_start_r <= 1'b1;
          state_r     <= ST_DV_L;
        end
        ST_DV_L: begin
          if (div_rsp.done) state_r <= ST_LD_R;
        end
        ST_LD_R: begin
          req_start_r <= 1'b1;
          state_r     <= ST_DV_R;
        end
        ST_DV_R: begin
          if (div_rsp.done) state_r <= ST_LD_D;
        end
        ST_LD_D: begin
          req_start_r <= 1'b1;
          state_r     <= ST_DV_D;
        end
        ST_DV_D: begin
          if (div_rsp.done) state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (changed_r) begin
            if ($signed(speed_avg) > $signed(peak_r)) peak_r <= speed_avg;
            distance_r    <= distance_r + step_r;
            last_left_r   <= in_left_r;
            last_right_r  <= in_right_r;
            last_change_r <= in_us_r;
          end
          win_pend_r <= 1'b1;
          state_r    <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_left_r  <= in_tdata[15:0];
      in_right_r <= in_tdata[31:16];
      in_us_r    <= in_tdata[47:32];
      in_ms_r    <= in_tdata[79:48];
    end
    if (state_r == ST_DELTA) begin
      changed_r <= changed;
      dl_r      <= in_left_r - last_left_r;
      dr_r      <= in_right_r - last_right_r;
      // A zero gap counts as one microsecond
      gap_r     <= ((in_us_r - last_change_r) == 16'd0) ? 16'd1 : (in_us_r - last_change_r);
    end
    if (state_r == ST_DEN) begin
      den_r  <= gap_r * SPEED_DEN;
      half_r <= dist_half;
    end
    if (state_r == ST_LD_L) begin
      req_num_r <= DIV_NUM_W'(mag16(dl_r) * SPEED_NUM);
      req_den_r <= den_r;
    end
    if (state_r == ST_DV_L && div_rsp.done) begin
      sl_r <= sat_speed(dl_r[15], div_rsp);
    end
    if (state_r == ST_LD_R) begin
      req_num_r <= DIV_NUM_W'(mag16(dr_r) * SPEED_NUM);
    end
    if (state_r == ST_DV_R && div_rsp.done) begin
      sr_r <= sat_speed(dr_r[15], div_rsp);
    end
    if (state_r == ST_LD_D) begin
      req_num_r <= DIV_NUM_W'(mag16(half_r) * DIST_NUM);
      req_den_r <= DIV_DEN_W'(DIST_DEN);
    end
    if (state_r == ST_DV_D && div_rsp.done) begin
      step_r <= half_r[15] ? (32'd0 - {15'b0, div_rsp.quo}) : {15'b0, div_rsp.quo};
    end
    if (state_r == ST_FIN) begin
      speed_r <= changed_r ? speed_avg : 16'd0;
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a beat is in work");

  a_still_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[80]) |-> (out_tdata[79:64] == 16'h0000 &&
                                        out_tdata[31:16] == 16'h0000))
    else $error("standstill result carries stale peak or average");

  a_peak_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[31])
    else $error("peak speed went negative");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DV_L || state_r == ST_DV_R || state_r == ST_DV_D))
    else $error("divider finished outside a divide step");
`endif

endmodule

// ===== sim/odometry_monitor.sv =====
module odometry_monitor import weo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen,
  output int          standstills,
  output int          window_updates
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SPEED_SCALE = 64'sd1225221134;
  localparam longint SPEED_DIV   = 64'sd9097;
  localparam int     STEP_SCALE  = 1225;
  localparam int     STEP_DIV    = 9097;

  typedef struct packed {
    logic [6:0]         pad;
    logic               moving;
    logic signed [15:0] avg;
    logic signed [31:0] distance;
    logic signed [15:0] peak;
    logic signed [15:0] speed;
  } odo_result_t;

  odo_result_t expected_odo[$];

  logic [15:0] interval_ms;
  logic [15:0] standstill_us;
  logic [15:0] prev_left;
  logic [15:0] prev_right;
  logic [15:0] prev_change_us;
  logic [31:0] dist_acc;
  logic [31:0] win_start_ms;
  logic [31:0] win_dist;
  int          peak;
  int          avg_vel;

  initial begin
    mismatches     = 0;
    outstanding    = 0;
    results_seen   = 0;
    standstills    = 0;
    window_updates = 0;
  end

  function automatic int clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic void compare_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic predict_odometry(input logic [79:0] beat);
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] now_us;
    logic [31:0] now_ms;
    logic [15:0] diff;
    logic [15:0] idle;
    longint      gap;
    longint      gain;
    int          dl;
    int          dr;
    int          sl;
    int          sr;
    int          spd;
    int          stp;
    odo_result_t r;
    left   = beat[15:0];
    right  = beat[31:16];
    now_us = beat[47:32];
    now_ms = beat[79:48];
    spd    = 0;
    if (left != prev_left || right != prev_right) begin
      diff = now_us - prev_change_us;
      gap  = (diff == 16'd0) ? 64'sd1 : longint'(diff);
      diff = left - prev_left;
      dl   = $signed(diff);
      diff = right - prev_right;
      dr   = $signed(diff);
      sl   = clamp16((longint'(dl) * SPEED_SCALE) / (gap * SPEED_DIV));
      sr   = clamp16((longint'(dr) * SPEED_SCALE) / (gap * SPEED_DIV));
      spd  = (sl + sr) / 2;
      if (spd > peak) peak = spd;
      stp  = (((dl + dr) / 2) * STEP_SCALE) / STEP_DIV;
      dist_acc       = dist_acc + stp;
      prev_left      = left;
      prev_right     = right;
      prev_change_us = now_us;
    end
    idle = now_us - prev_change_us;
    if (idle > standstill_us) begin
      // stopped: restart the window from the current distance
      r.moving     = 1'b0;
      win_start_ms = '0;
      avg_vel      = 0;
      peak         = 0;
      win_dist     = dist_acc;
      standstills++;
    end else begin
      r.moving = 1'b1;
      if ((now_ms - win_start_ms) > {16'd0, interval_ms}) begin
        gain         = longint'($signed(dist_acc)) - longint'($signed(win_dist));
        win_start_ms = now_ms;
        avg_vel      = clamp16(gain / 2);
        win_dist     = dist_acc;
        window_updates++;
      end
      if (spd > peak) peak = spd;
    end
    r.pad      = '0;
    r.speed    = spd[15:0];
    r.peak     = peak[15:0];
    r.distance = dist_acc;
    r.avg      = avg_vel[15:0];
    expected_odo.push_back(r);
  endtask

  task automatic check_result(input odo_result_t got);
    odo_result_t want;
    results_seen++;
    if (expected_odo.size() == 0) begin
      $error("result beat with no sample pending: %h", got);
      mismatches++;
      return;
    end
    want = expected_odo.pop_front();
    compare_field("speed", want.speed, got.speed);
    compare_field("max_speed", want.peak, got.peak);
    compare_field("distance", want.distance, got.distance);
    compare_field("average_velocity", want.avg, got.avg);
    compare_field("moving", {63'd0, want.moving}, {63'd0, got.moving});
    compare_field("padding", {57'd0, want.pad}, {57'd0, got.pad});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      interval_ms    = AVG_INTERVAL_RST;
      standstill_us  = STANDSTILL_RST;
      prev_left      = '0;
      prev_right     = '0;
      prev_change_us = '0;
      dist_acc       = '0;
      win_start_ms   = '0;
      win_dist       = '0;
      peak           = 0;
      avg_vel        = 0;
      expected_odo.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_AVG_INTERVAL: interval_ms   = cfg_wdata;
          CFG_STANDSTILL:   standstill_us = cfg_wdata;
        endcase
      end
      // retire first so a stray result in the same cycle is not matched to a new sample
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) predict_odometry(in_tdata);
    end
    outstanding <= expected_odo.size();
  end

endmodule

// ===== sim/wheel_encoder_odometry_core_tb.sv =====
module wheel_encoder_odometry_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import weo_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 100;
  localparam int PHASE_SAMPLES = 100;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        cfg_we;
  logic        cfg_addr;
  logic [15:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int results_seen;
  int standstills;
  int window_updates;

  logic [15:0] cur_left;
  logic [15:0] cur_right;
  logic [15:0] cur_us;
  logic [31:0] cur_ms;
  logic [15:0] cur_interval;
  logic [15:0] cur_timeout;
  logic        tx_burst;
  logic        rx_burst;
  int          ready_wait;
  int          quiet_cycles;
  int          samples_sent;
  int          settings_used;

  wheel_encoder_odometry_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  odometry_monitor monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_seen   (results_seen),
    .standstills    (standstills),
    .window_updates (window_updates)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // result side: outside a burst, stall after most beats for a freshly drawn number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_wait <= 0;
    end else if (out_tvalid && out_tready) begin
      if (!rx_burst && $urandom_range(0, 13) != 0) begin
        out_tready <= 1'b0;
        ready_wait <= $urandom_range(0, 12);
      end
    end else if (!out_tready) begin
      if (ready_wait == 0) begin
        out_tready <= 1'b1;
      end else begin
        ready_wait <= ready_wait - 1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("wheel_encoder_odometry_core: mismatch");
        $finish;
      end
    end
  end

  task automatic send_sample();
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cur_ms, cur_us, cur_right, cur_left};
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  task automatic advance(input int dl, input int dr, input int dus, input logic [31:0] dms);
    cur_left  = cur_left + 16'(dl);
    cur_right = cur_right + 16'(dr);
    cur_us    = cur_us + 16'(dus);
    cur_ms    = cur_ms + dms;
    send_sample();
  endtask

  task automatic send_noise();
    cur_left  = 16'($urandom);
    cur_right = 16'($urandom);
    cur_us    = 16'($urandom);
    cur_ms    = $urandom;
    send_sample();
  endtask

  task automatic write_reg(input logic addr, input logic [15:0] value);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_AVG_INTERVAL) cur_interval = value;
    else cur_timeout = value;
  endtask

  task automatic apply_setting(input logic [15:0] interval, input logic [15:0] timeout);
    write_reg(CFG_AVG_INTERVAL, interval);
    write_reg(CFG_STANDSTILL, timeout);
    settings_used++;
  endtask

  task automatic run_random_phase(input int count);
    int stop_at;
    int kind;
    int big;
    int dir;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) begin
      kind     = $urandom_range(0, 99);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst <= ($urandom_range(0, 3) == 0);
      if (kind < 55) begin
        // cruise: mostly small count steps, gaps mostly inside the standstill timeout
        repeat ($urandom_range(3, 12)) begin
          big = ($urandom_range(0, 9) == 0);
          advance(big ? int'($urandom_range(0, 8000)) - 4000 : int'($urandom_range(0, 40)) - 20,
                  big ? int'($urandom_range(0, 8000)) - 4000 : int'($urandom_range(0, 40)) - 20,
                  $urandom_range(0, cur_timeout),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70000)
                                              : $urandom_range(0, 400));
        end
      end else if (kind < 65) begin
        // sprint: full-scale steps in one window, then close it to saturate the average
        dir = $urandom_range(0, 1);
        repeat (16) advance(dir ? 32767 : -32768, dir ? 32767 : -32768,
                            $urandom_range(0, 3), 32'd0);
        advance(1, 1, 1, {16'd0, cur_interval} + 32'd1);
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 4))
          advance(0, 0, $urandom_range(0, 65535), $urandom_range(0, 5000));
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 6))
          advance(0, 0, $urandom_range(0, 50), $urandom_range(0, 50));
      end else begin
        repeat ($urandom_range(1, 3)) send_noise();
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = CFG_AVG_INTERVAL;
    cfg_wdata     = '0;
    ready_wait    = 0;
    quiet_cycles  = 0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    samples_sent  = 0;
    settings_used = 1;
    cur_left      = '0;
    cur_right     = '0;
    cur_us        = '0;
    cur_ms        = '0;
    cur_interval  = AVG_INTERVAL_RST;
    cur_timeout   = STANDSTILL_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed samples at the reset register values
    advance(0, 0, 0, 32'd0);
    advance(1, 0, 0, 32'd0);
    advance(32767, 32767, 1, 32'd0);
    advance(-32768, -32768, 1, 32'd0);
    advance(5, -5, 65535, 32'd0);
    advance(100, 90, 1000, 32'd2000);
    advance(100, 90, 1000, 32'd1);
    advance(0, 0, 5000, 32'd0);
    advance(0, 0, 1, 32'd0);
    advance(3, 3, 10, 32'd0);
    advance(1, 0, 7, 32'hFFFF_F000);
    advance(0, 1, 7, 32'h0000_2000);
    advance(2, 2, 65530, 32'd0);
    advance(2, 2, 10, 32'd0);
    advance(-1, 1, 20, 32'd0);
    advance(-7, -3, 20, 32'd3000);
    repeat (4) send_noise();

    apply_setting(16'd1, 16'd1);
    run_random_phase(PHASE_SAMPLES);
    apply_setting(16'hFFFF, 16'hFFFF);
    run_random_phase(PHASE_SAMPLES);
    apply_setting(16'd50, 16'd3000);
    run_random_phase(PHASE_SAMPLES);
    apply_setting(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    run_random_phase(PHASE_SAMPLES);
    apply_setting(16'($urandom_range(1, 400)), 16'($urandom_range(1, 65535)));
    run_random_phase(PHASE_SAMPLES);
    apply_setting(AVG_INTERVAL_RST, STANDSTILL_RST);
    run_random_phase(PHASE_SAMPLES);

    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples over %0d register settings, %0d results checked",
             samples_sent, settings_used, results_seen);
    $display("%0d standstill results and %0d window updates predicted",
             standstills, window_updates);
    if (mismatches == 0) begin
      $display("wheel_encoder_odometry_core: match");
    end else begin
      $display("wheel_encoder_odometry_core: mismatch");
    end
    $finish;
  end

endmodule
